/* hdl/nmea_utc_pkg.sv */
// nmea utc sentence parser package: character codes, field limits and shared types
// no dependencies

package nmea_utc_pkg;

    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_NL     = 8'h0A;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CHAR_NUL    = 8'h00;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_R      = 8'h52;
    localparam logic [7:0] CHAR_M      = 8'h4D;
    localparam logic [7:0] CHAR_C      = 8'h43;
    localparam logic [7:0] CHAR_G      = 8'h47;
    localparam logic [7:0] CHAR_A      = 8'h41;
    localparam logic [7:0] CHAR_Z      = 8'h5A;
    localparam logic [7:0] CHAR_D      = 8'h44;

    localparam logic [3:0] COMMA_TIME = 4'd1;
    localparam logic [3:0] COMMA_DATE = 4'd9;
    localparam logic [2:0] FIELD_LEN  = 3'd6;

    typedef logic [3:0][7:0] head_t;
    typedef logic [5:0][7:0] field_chars_t;

    typedef struct packed {
        logic [6:0] sentence_length;
        logic       utc_sentence;
        logic       clock_update;
        logic [7:0] hour;
        logic [7:0] minute;
        logic [7:0] second;
        logic [7:0] day;
        logic [7:0] month;
        logic [7:0] year;
    } result_t;

endpackage

/* hdl/nmea_utc_in_if.sv */
// byte input channel: valid/ready handshake with one received byte per item
// no dependencies

interface nmea_utc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

/* hdl/nmea_utc_out_if.sv */
// result channel: valid/ready handshake carrying one decoded sentence per item
// no dependencies

interface nmea_utc_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] sentence_length;
    logic       utc_sentence;
    logic       clock_update;
    logic [7:0] hour;
    logic [7:0] minute;
    logic [7:0] second;
    logic [7:0] day;
    logic [7:0] month;
    logic [7:0] year;

    modport source (output valid, output sentence_length, output utc_sentence,
                    output clock_update, output hour, output minute, output second,
                    output day, output month, output year, input ready);
    modport sink (input valid, input sentence_length, input utc_sentence,
                  input clock_update, input hour, input minute, input second,
                  input day, input month, input year, output ready);
endinterface

/* hdl/nmea_utc_decode.sv */
// sentence type match and two-digit time/date conversion for a closed sentence
// depends on nmea_utc_pkg

module nmea_utc_decode
    import nmea_utc_pkg::*;
(
    input  head_t        head,
    input  logic [3:0]   comma_count,
    input  field_chars_t time_chars,
    input  field_chars_t date_chars,
    input  logic [6:0]   sentence_length,
    output result_t      result
);

    function automatic logic [7:0] digit_pair(input logic [7:0] hi, input logic [7:0] lo);
        logic [7:0] times_ten;
        times_ten = {hi[4:0], 3'b000} + {hi[6:0], 1'b0};
        return times_ten + lo - 8'd16;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    logic dollar;
    logic rmc;
    logic gga;
    logic zda;
    logic update;

    always_comb
    begin
        dollar = head[0] == CHAR_DOLLAR;
        rmc    = dollar && head[1] == CHAR_R && head[2] == CHAR_M && head[3] == CHAR_C;
        gga    = dollar && head[1] == CHAR_G && head[2] == CHAR_G && head[3] == CHAR_A;
        zda    = dollar && head[1] == CHAR_Z && head[2] == CHAR_D && head[3] == CHAR_A;
        update = rmc && comma_count == COMMA_DATE && is_digit(time_chars[0])
                 && is_digit(date_chars[0]);

        result.sentence_length = sentence_length;
        result.utc_sentence    = rmc || gga || zda;
        result.clock_update    = update;
        result.hour            = update ? digit_pair(time_chars[0], time_chars[1]) : 8'd0;
        result.minute          = update ? digit_pair(time_chars[2], time_chars[3]) : 8'd0;
        result.second          = update ? digit_pair(time_chars[4], time_chars[5]) : 8'd0;
        result.day             = update ? digit_pair(date_chars[0], date_chars[1]) : 8'd0;
        result.month           = update ? digit_pair(date_chars[2], date_chars[3]) : 8'd0;
        result.year            = update ? digit_pair(date_chars[4], date_chars[5]) : 8'd0;
    end

endmodule

/* hdl/nmea_utc_sentence_parser.sv */
// nmea utc sentence parser top level: byte capture, sentence state and result register
// path: a taken byte sits in the input register; its newline result loads the output register
// throughput: one byte per cycle; the input register stalls only while a newline result
//   waits behind an output register that is not taken
// reset: all sentence state clears to an empty sentence, no item held on either side
// depends on nmea_utc_pkg, nmea_utc_in_if, nmea_utc_out_if, nmea_utc_decode

module nmea_utc_sentence_parser
    import nmea_utc_pkg::*;
#(
    parameter int STORE_DEPTH = 128
)
(
    input logic           clk,
    input logic           rst_n,
    nmea_utc_in_if.sink   rx,
    nmea_utc_out_if.source report
);

    localparam int FILL_W = $clog2(STORE_DEPTH);
    localparam logic [FILL_W-1:0] FILL_LIM1 = FILL_W'(STORE_DEPTH - 1);
    localparam logic [FILL_W-1:0] FILL_LIM2 = FILL_W'(STORE_DEPTH - 2);

    logic              s1_valid_reg, s1_valid_next;
    logic [7:0]        s1_byte_reg;
    logic [FILL_W-1:0] fill_count_reg, fill_count_next;
    head_t             head_reg, head_next;
    logic [3:0]        comma_count_reg, comma_count_next;
    logic [2:0]        field_offset_reg, field_offset_next;
    field_chars_t      time_reg, time_next;
    field_chars_t      date_reg, date_next;
    logic              scan_stop_reg, scan_stop_next;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg;

    logic              is_dollar, is_nl, is_cr;
    logic              fill_ok, room;
    logic              s1_result, s1_go, upd_en;

    logic [FILL_W-1:0] b_fill, s_fill;
    head_t             b_head, s_head;
    logic [3:0]        b_comma, s_comma;
    logic [2:0]        b_off, s_off;
    field_chars_t      b_time, s_time, b_date, s_date;
    logic              b_stop, s_stop;
    logic [FILL_W+6:0] len_wide;
    result_t           res_d;

    // handshake
    always_comb
    begin
        is_dollar = s1_byte_reg == CHAR_DOLLAR;
        is_nl     = s1_byte_reg == CHAR_NL;
        is_cr     = s1_byte_reg == CHAR_CR;
        fill_ok   = fill_count_reg != '0 && fill_count_reg < FILL_LIM2;
        room      = fill_count_reg < FILL_LIM1;
        s1_result = s1_valid_reg && is_nl && fill_ok;
        s1_go     = !s1_result || !out_valid_reg || report.ready;
        upd_en    = s1_valid_reg && s1_go;
        rx.ready  = !s1_valid_reg || s1_go;

        if (rx.valid && rx.ready)
            s1_valid_next = 1'b1;
        else if (s1_go)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (s1_result && s1_go)
            out_valid_next = 1'b1;
        else if (report.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // storing the current byte into the sentence
    always_comb
    begin
        if (is_dollar)
        begin
            b_fill  = '0;
            b_head  = '0;
            b_comma = '0;
            b_off   = '0;
            b_time  = '0;
            b_date  = '0;
            b_stop  = 1'b0;
        end
        else
        begin
            b_fill  = fill_count_reg;
            b_head  = head_reg;
            b_comma = comma_count_reg;
            b_off   = field_offset_reg;
            b_time  = time_reg;
            b_date  = date_reg;
            b_stop  = scan_stop_reg;
        end

        s_fill = b_fill + 1'b1;

        s_head = b_head;
        if (b_fill == FILL_W'(0))
            s_head[0] = s1_byte_reg;
        if (b_fill == FILL_W'(3))
            s_head[1] = s1_byte_reg;
        if (b_fill == FILL_W'(4))
            s_head[2] = s1_byte_reg;
        if (b_fill == FILL_W'(5))
            s_head[3] = s1_byte_reg;

        s_time = b_time;
        s_date = b_date;
        s_off  = b_off;
        if (b_comma != '0 && b_off < FIELD_LEN)
        begin
            for (int i = 0; i < 6; i++)
            begin
                if (b_off == 3'(i))
                begin
                    if (b_comma == COMMA_DATE)
                        s_date[i] = s1_byte_reg;
                    else
                        s_time[i] = s1_byte_reg;
                end
            end
            s_off = b_off + 3'd1;
        end

        s_comma = b_comma;
        s_stop  = b_stop;
        if (!b_stop && b_comma < COMMA_DATE)
        begin
            if (s1_byte_reg == CHAR_NUL)
                s_stop = 1'b1;
            else if (s1_byte_reg == CHAR_COMMA)
            begin
                s_comma = b_comma + 4'd1;
                if (s_comma == COMMA_TIME || s_comma == COMMA_DATE)
                    s_off = '0;
            end
        end

        len_wide = (FILL_W + 7)'(s_fill);
    end

    // next sentence state
    always_comb
    begin
        fill_count_next   = fill_count_reg;
        head_next         = head_reg;
        comma_count_next  = comma_count_reg;
        field_offset_next = field_offset_reg;
        time_next         = time_reg;
        date_next         = date_reg;
        scan_stop_next    = scan_stop_reg;

        if (upd_en)
        begin
            priority if (is_dollar || (!is_nl && !is_cr && room))
            begin
                fill_count_next   = s_fill;
                head_next         = s_head;
                comma_count_next  = s_comma;
                field_offset_next = s_off;
                time_next         = s_time;
                date_next         = s_date;
                scan_stop_next    = s_stop;
            end
            else if (!is_cr)
            begin
                fill_count_next   = '0;
                head_next         = '0;
                comma_count_next  = '0;
                field_offset_next = '0;
                time_next         = '0;
                date_next         = '0;
                scan_stop_next    = 1'b0;
            end
            else
            begin
                scan_stop_next = scan_stop_reg;
            end
        end
    end

    nmea_utc_decode u_decode (
        .head            (s_head),
        .comma_count     (s_comma),
        .time_chars      (s_time),
        .date_chars      (s_date),
        .sentence_length (len_wide[6:0]),
        .result          (res_d)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            fill_count_reg   <= '0;
            head_reg         <= '0;
            comma_count_reg  <= '0;
            field_offset_reg <= '0;
            time_reg         <= '0;
            date_reg         <= '0;
            scan_stop_reg    <= 1'b0;
        end
        else
        begin
            s1_valid_reg     <= s1_valid_next;
            out_valid_reg    <= out_valid_next;
            fill_count_reg   <= fill_count_next;
            head_reg         <= head_next;
            comma_count_reg  <= comma_count_next;
            field_offset_reg <= field_offset_next;
            time_reg         <= time_next;
            date_reg         <= date_next;
            scan_stop_reg    <= scan_stop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
            s1_byte_reg <= rx.rx_byte;
        if (s1_result && s1_go)
            out_reg <= res_d;
    end

    assign report.valid           = out_valid_reg;
    assign report.sentence_length = out_reg.sentence_length;
    assign report.utc_sentence    = out_reg.utc_sentence;
    assign report.clock_update    = out_reg.clock_update;
    assign report.hour            = out_reg.hour;
    assign report.minute          = out_reg.minute;
    assign report.second          = out_reg.second;
    assign report.day             = out_reg.day;
    assign report.month           = out_reg.month;
    assign report.year            = out_reg.year;

    a_comma_sat: assert property (@(posedge clk) disable iff (!rst_n)
        comma_count_reg <= COMMA_DATE)
        else $error("comma count past saturation");

    a_offset_range: assert property (@(posedge clk) disable iff (!rst_n)
        field_offset_reg <= FIELD_LEN)
        else $error("field offset out of range");

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= FILL_LIM1)
        else $error("fill count past store depth");

    a_update_is_utc: assert property (@(posedge clk) disable iff (!rst_n)
        report.valid && report.clock_update |-> report.utc_sentence)
        else $error("clock update on a non-utc sentence");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        s1_result && s1_go |=> out_valid_reg)
        else $error("newline result not loaded");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_go |=> s1_valid_reg && $stable(s1_byte_reg))
        else $error("stalled byte lost");

endmodule
